>>> rtl/assert_macros.svh
// assertion macros used by the core rtl file
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> rtl/stms_pkg.sv
`timescale 1ns / 1ps
// shared types, sizes and colour table of the sparse tile map sampler
// no dependencies
package stms_pkg;

	// sizes of the map and its stores
	localparam int MAP_SIDE_MAX     = 256;
	localparam int MAX_TILES        = 256;
	localparam int TILE_SIDE        = 32;
	localparam int COORD_FRAC_BITS  = 16;

	localparam int QUARTER_MAX      = MAP_SIDE_MAX / 4;
	localparam int COARSE_BYTES     = (MAP_SIDE_MAX * MAP_SIDE_MAX) / 4;
	localparam int TILE_BYTES       = (TILE_SIDE * TILE_SIDE) / 4;
	localparam int TILE_STORE_BYTES = MAX_TILES * TILE_BYTES;
	localparam int CELL_COUNT       = MAP_SIDE_MAX * MAP_SIDE_MAX;

	// derived widths
	localparam int CELL_BITS  = $clog2(MAP_SIDE_MAX);
	localparam int CELL_W     = 2 * CELL_BITS;
	localparam int TILE_BITS  = $clog2(TILE_SIDE);
	localparam int TNUM_W     = $clog2(MAX_TILES);
	localparam int CADDR_W    = $clog2(COARSE_BYTES);
	localparam int TADDR_W    = $clog2(TILE_STORE_BYTES);
	localparam int QW_W       = 7;
	localparam int SAMPLE_W   = 17;
	localparam int SIDE_W     = $clog2(MAP_SIDE_MAX + 1);
	localparam int PX_W       = SAMPLE_W + SIDE_W;
	localparam int IX_W       = PX_W - COORD_FRAC_BITS;

	// register map
	localparam int REG_QW_IDX   = 0;
	localparam int QW_RESET     = 64;

	// colours
	localparam logic [31:0] COLOUR_WHITE = 32'hFFFF_FFFF;
	localparam logic [31:0] COLOUR_ONE   = 32'hFF00_00FF;
	localparam logic [31:0] COLOUR_TWO   = 32'hFF00_FF00;
	localparam logic [31:0] COLOUR_THREE = 32'hFFFF_0000;

	typedef enum logic [1:0] {
		CMD_COARSE = 2'd0,
		CMD_TILE   = 2'd1,
		CMD_BIND   = 2'd2,
		CMD_SAMPLE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SRC_COARSE = 2'd0,
		SRC_TILE   = 2'd1,
		SRC_NONE   = 2'd2
	} src_t;

	// one entry of the cell to tile index
	typedef struct packed {
		logic              valid;
		logic [TNUM_W-1:0] tile;
	} cidx_entry_t;

	// class to colour lookup
	function automatic logic [31:0] class_colour(input logic [1:0] cls);
		logic [31:0] c;
		case (cls)
			2'd1:    c = COLOUR_ONE;
			2'd2:    c = COLOUR_TWO;
			2'd3:    c = COLOUR_THREE;
			default: c = COLOUR_WHITE;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/sparse_tile_map_sampler_core.sv
`timescale 1ns / 1ps
// top level of the sparse tile map sampler: command pipeline around three stores
// depends on stms_pkg and assert_macros.svh
//
// usage
// - a request is taken at a rising edge with start high and busy low; cmd picks a
//   coarse byte write, a tile byte write, a cell to tile bind or a sample
// - only a sample gives a result: rgba, pixel_class, colour_source and outside_map
//   are shown for one cycle with done high; the request passes the stage 1, stage 2
//   and stage 3 registers and then the result registers, which drive done; the receiver
//   cannot stall, so done is never held
// - one request per cycle is taken while busy is low, whatever the mix of commands; the
//   coarse map and cell index are read by the first stage, the tile store by the
//   second, each memory with a single registered read per cycle
// - a bind to a cell already bound keeps the first tile; a bind being written while
//   the next request reads the same cell is forwarded
// - after reset busy stays high while all 65536 entries of the cell index are
//   cleared, one entry a cycle; the coarse map and tile store are not cleared
// - map_quarter_width sits at byte address 0 of the apb port and resets to 64;
//   write it only while no sample is in flight
module sparse_tile_map_sampler_core (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] store_addr,
	input  logic [7:0]  store_byte,
	input  logic [7:0]  tile_col,
	input  logic [7:0]  tile_row,
	input  logic [7:0]  tile_number,
	input  logic [16:0] sample_x,
	input  logic [16:0] sample_y,
	// result channel
	output logic        done,
	output logic [31:0] rgba,
	output logic [1:0]  pixel_class,
	output logic [1:0]  colour_source,
	output logic        outside_map,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CB  = stms_pkg::CELL_BITS;
	localparam int TB  = stms_pkg::TILE_BITS;
	localparam int FR  = stms_pkg::COORD_FRAC_BITS;
	localparam int PXW = stms_pkg::PX_W;
	localparam int IXW = stms_pkg::IX_W;
	localparam int QWW = stms_pkg::QW_W;

	// configuration register
	logic [QWW-1:0] qw_q;
	logic           cfg_wr;
	logic           cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (32'(paddr[2]) == stms_pkg::REG_QW_IDX);
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
	assign prdata  = cfg_hit ? 32'(qw_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= QWW'(stms_pkg::QW_RESET);
		end else if (cfg_wr) begin
			qw_q <= pwdata[QWW-1:0];
		end
	end

	// clamped quarter width and map side
	logic [QWW-1:0]                qw_eff;
	logic [stms_pkg::SIDE_W-1:0]   side;

	always_comb begin
		if (qw_q == '0) begin
			qw_eff = QWW'(1);
		end else if (32'(qw_q) > stms_pkg::QUARTER_MAX) begin
			qw_eff = QWW'(stms_pkg::QUARTER_MAX);
		end else begin
			qw_eff = qw_q;
		end
		side = stms_pkg::SIDE_W'({qw_eff, 2'b00});
	end

	// clearing pass over the cell index after reset
	logic                   clr_q;
	logic [stms_pkg::CELL_W-1:0] clr_addr_q;
	logic                   clr_last;

	assign clr_last = (32'(clr_addr_q) == stms_pkg::CELL_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_last) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign busy = clr_q;

	logic accept;
	logic sample_acc;
	assign accept     = start && !busy;
	assign sample_acc = accept && (stms_pkg::cmd_t'(cmd) == stms_pkg::CMD_SAMPLE);

	// stage 1: request with scaled coordinates
	logic                   vld_s1;
	stms_pkg::cmd_t         cmd_s1;
	logic [15:0]            addr_s1;
	logic [7:0]             byte_s1;
	logic [7:0]             col_s1;
	logic [7:0]             row_s1;
	logic [7:0]             tnum_s1;
	logic [PXW-1:0]         px_s1;
	logic [PXW-1:0]         py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= stms_pkg::cmd_t'(cmd);
		addr_s1 <= store_addr;
		byte_s1 <= store_byte;
		col_s1  <= tile_col;
		row_s1  <= tile_row;
		tnum_s1 <= tile_number;
		px_s1   <= PXW'(sample_x) * PXW'(side);
		py_s1   <= PXW'(sample_y) * PXW'(side);
	end

	// stage 1 decode: cell, coarse address, sub-cell position
	logic [IXW-1:0]                ix_s1;
	logic [IXW-1:0]                iy_s1;
	logic                          outside_s1;
	logic [stms_pkg::CADDR_W-1:0]  caddr_s1;
	logic [stms_pkg::CELL_W-1:0]   cell_s1;
	logic [TB-1:0]                 tx_s1;
	logic [TB-1:0]                 ty_s1;
	logic                          bind_ok_s1;

	always_comb begin
		ix_s1      = px_s1[PXW-1:FR];
		iy_s1      = py_s1[PXW-1:FR];
		outside_s1 = (ix_s1 >= IXW'(side)) || (iy_s1 >= IXW'(side));
		caddr_s1   = stms_pkg::CADDR_W'(qw_eff) * stms_pkg::CADDR_W'(iy_s1)
			+ stms_pkg::CADDR_W'(ix_s1 >> 2);
		tx_s1      = px_s1[FR-1 -: TB];
		ty_s1      = py_s1[FR-1 -: TB];
		bind_ok_s1 = (32'(col_s1) < stms_pkg::MAP_SIDE_MAX)
			&& (32'(row_s1) < stms_pkg::MAP_SIDE_MAX)
			&& (32'(tnum_s1) < stms_pkg::MAX_TILES);
		if (cmd_s1 == stms_pkg::CMD_BIND) begin
			cell_s1 = {CB'(row_s1), CB'(col_s1)};
		end else begin
			cell_s1 = {iy_s1[CB-1:0], ix_s1[CB-1:0]};
		end
	end

	// coarse map: written by coarse requests and read by samples in stage 1
	logic [7:0] coarse_mem [stms_pkg::COARSE_BYTES];
	logic [7:0] coarse_rd;
	logic       coarse_we;

	assign coarse_we = vld_s1 && (cmd_s1 == stms_pkg::CMD_COARSE)
		&& (32'(addr_s1) < stms_pkg::COARSE_BYTES);

	always_ff @(posedge clk) begin
		if (coarse_we) begin
			coarse_mem[addr_s1[stms_pkg::CADDR_W-1:0]] <= byte_s1;
		end
		coarse_rd <= coarse_mem[caddr_s1];
	end

	// stage 2 registers
	logic                   vld_s2;
	stms_pkg::cmd_t         cmd_s2;
	logic [15:0]            addr_s2;
	logic [7:0]             byte_s2;
	logic [stms_pkg::CELL_W-1:0] cell_s2;
	logic [stms_pkg::TNUM_W-1:0] tnum_s2;
	logic                   bind_ok_s2;
	logic                   outside_s2;
	logic [1:0]             cshift_s2;
	logic [TB-1:0]          tx_s2;
	logic [TB-1:0]          ty_s2;
	logic                   fwd_s2;
	logic [stms_pkg::TNUM_W-1:0] fwd_tile_s2;

	// cell index: read in stage 1, bind written in stage 2, cleared after reset
	stms_pkg::cidx_entry_t  cidx_mem [stms_pkg::CELL_COUNT];
	stms_pkg::cidx_entry_t  cidx_rd;
	stms_pkg::cidx_entry_t  entry_s2;
	stms_pkg::cidx_entry_t  cidx_wd;
	logic [stms_pkg::CELL_W-1:0] cidx_wa;
	logic                   cidx_we;
	logic                   bind_we;

	always_comb begin
		// a bind still being written ahead of this request wins over stale read data
		if (fwd_s2) begin
			entry_s2.valid = 1'b1;
			entry_s2.tile  = fwd_tile_s2;
		end else begin
			entry_s2 = cidx_rd;
		end
		bind_we = vld_s2 && (cmd_s2 == stms_pkg::CMD_BIND) && bind_ok_s2
			&& !entry_s2.valid;
		if (clr_q) begin
			cidx_we       = 1'b1;
			cidx_wa       = clr_addr_q;
			cidx_wd       = '0;
		end else begin
			cidx_we       = bind_we;
			cidx_wa       = cell_s2;
			cidx_wd.valid = 1'b1;
			cidx_wd.tile  = tnum_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cidx_we) begin
			cidx_mem[cidx_wa] <= cidx_wd;
		end
		cidx_rd <= cidx_mem[cell_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			fwd_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			fwd_s2 <= bind_we && (cell_s2 == cell_s1);
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2      <= cmd_s1;
		addr_s2     <= addr_s1;
		byte_s2     <= byte_s1;
		cell_s2     <= cell_s1;
		tnum_s2     <= stms_pkg::TNUM_W'(tnum_s1);
		bind_ok_s2  <= bind_ok_s1;
		outside_s2  <= outside_s1;
		cshift_s2   <= ix_s1[1:0];
		tx_s2       <= tx_s1;
		ty_s2       <= ty_s1;
		fwd_tile_s2 <= tnum_s2;
	end

	// stage 2: coarse class and tile byte address, rows stored bottom-up
	logic [1:0]                    coarse_cls_s2;
	logic [stms_pkg::TADDR_W-1:0]  taddr_s2;
	logic [7:0]                    coarse_shift;

	always_comb begin
		coarse_shift  = coarse_rd >> {cshift_s2, 1'b0};
		coarse_cls_s2 = coarse_shift[1:0];
		taddr_s2      = {entry_s2.tile, ~ty_s2, tx_s2[TB-1:2]};
	end

	// tile store: written by tile requests and read by samples in stage 2
	logic [7:0] tile_mem [stms_pkg::TILE_STORE_BYTES];
	logic [7:0] tile_rd;
	logic       tile_we;

	assign tile_we = vld_s2 && (cmd_s2 == stms_pkg::CMD_TILE)
		&& (32'(addr_s2) < stms_pkg::TILE_STORE_BYTES);

	always_ff @(posedge clk) begin
		if (tile_we) begin
			tile_mem[addr_s2[stms_pkg::TADDR_W-1:0]] <= byte_s2;
		end
		tile_rd <= tile_mem[taddr_s2];
	end

	// stage 3 registers, samples only
	logic       vld_s3;
	logic       outside_s3;
	logic [1:0] coarse_cls_s3;
	logic       present_s3;
	logic [1:0] tshift_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2 && (cmd_s2 == stms_pkg::CMD_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		outside_s3    <= outside_s2;
		coarse_cls_s3 <= coarse_cls_s2;
		present_s3    <= entry_s2.valid;
		tshift_s3     <= tx_s2[1:0];
	end

	// stage 3: choose the class and colour
	logic [7:0]     tile_shift;
	logic [1:0]     tile_cls;
	logic [31:0]    rgba_s3;
	logic [1:0]     cls_s3;
	stms_pkg::src_t src_s3;

	always_comb begin
		tile_shift = tile_rd >> {tshift_s3, 1'b0};
		tile_cls   = tile_shift[1:0];
		rgba_s3    = stms_pkg::COLOUR_WHITE;
		cls_s3     = 2'd0;
		src_s3     = stms_pkg::SRC_NONE;
		if (!outside_s3) begin
			if (coarse_cls_s3 != 2'd0) begin
				rgba_s3 = stms_pkg::class_colour(coarse_cls_s3);
				cls_s3  = coarse_cls_s3;
				src_s3  = stms_pkg::SRC_COARSE;
			end else if (present_s3) begin
				rgba_s3 = stms_pkg::class_colour(tile_cls);
				cls_s3  = tile_cls;
				src_s3  = stms_pkg::SRC_TILE;
			end
		end
	end

	// result registers
	logic           done_q;
	logic [31:0]    rgba_q;
	logic [1:0]     cls_q;
	stms_pkg::src_t src_q;
	logic           outside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		rgba_q    <= rgba_s3;
		cls_q     <= cls_s3;
		src_q     <= src_s3;
		outside_q <= outside_s3;
	end

	assign done          = done_q;
	assign rgba          = rgba_q;
	assign pixel_class   = cls_q;
	assign colour_source = src_q;
	assign outside_map   = outside_q;

	// white result with no class and no source
	logic white_res;
	assign white_res = (rgba == stms_pkg::COLOUR_WHITE) && (pixel_class == 2'd0)
		&& (colour_source == stms_pkg::SRC_NONE);

	// checks
`include "assert_macros.svh"

	`ASSERT_HOLDS(a_result_latency, clk, arst_n, done == $past(sample_acc, 4))
	`ASSERT_NEVER(a_no_result_while_clearing, clk, arst_n, clr_q && (done || vld_s1))
	`ASSERT_HOLDS(a_outside_is_white, clk, arst_n, (done && outside_map) |-> white_res)
	`ASSERT_HOLDS(a_clear_ends_at_last, clk, arst_n, $fell(clr_q) |-> $past(clr_last))

endmodule

>>> tb/sparse_tile_map_sampler_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the sparse tile map sampler
// scoreboard class, request driver and apb writes; depends on stms_pkg and the core
module sparse_tile_map_sampler_core_tb;

	// the quiet limit sits well above the index clearing after reset, which clears all 65536 cells one by one
	localparam int unsigned STALL_LIMIT = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam logic [2:0] QW_ADDR = 3'(4 * stms_pkg::REG_QW_IDX);

	typedef struct {
		logic [31:0]    rgba;
		logic [1:0]     pixel_class;
		stms_pkg::src_t source;
		logic           outside;
	} sample_colour_t;

	// mirror of the three stores, the side register and the colours still to come
	class map_sample_scoreboard;
		bit [7:0] coarse_bytes [stms_pkg::COARSE_BYTES];
		bit       coarse_known [stms_pkg::COARSE_BYTES];
		bit [7:0] tile_bytes [stms_pkg::TILE_STORE_BYTES];
		bit       tile_known [stms_pkg::TILE_STORE_BYTES];
		bit       cell_bound [stms_pkg::CELL_COUNT];
		bit [7:0] cell_tile [stms_pkg::CELL_COUNT];
		int unsigned quarter = stms_pkg::QW_RESET;
		sample_colour_t pending_samples [$];
		int unsigned errors = 0;

		// zero reads as one, anything above the largest map saturates
		function void set_quarter(logic [31:0] value);
			int unsigned q;
			q = {25'd0, value[6:0]};
			if (q == 0) quarter = 1;
			else if (q > stms_pkg::QUARTER_MAX) quarter = stms_pkg::QUARTER_MAX;
			else quarter = q;
		endfunction

		// coarse byte, cell and tile byte offset that a point lands on
		function void locate(input logic [16:0] x, input logic [16:0] y, output bit outside,
				output int unsigned caddr, output int unsigned cshift,
				output int unsigned cell_no, output int unsigned toffs,
				output int unsigned tshift);
			int unsigned side, px, py, ix, iy, tx, ty, fmask;
			fmask = (1 << stms_pkg::COORD_FRAC_BITS) - 1;
			side = 4 * quarter;
			px = x * side;
			py = y * side;
			ix = px >> stms_pkg::COORD_FRAC_BITS;
			iy = py >> stms_pkg::COORD_FRAC_BITS;
			outside = (ix >= side) || (iy >= side);
			caddr = quarter * iy + ix / 4;
			cshift = 2 * (ix % 4);
			cell_no = iy * stms_pkg::MAP_SIDE_MAX + ix;
			tx = ((px & fmask) * stms_pkg::TILE_SIDE) >> stms_pkg::COORD_FRAC_BITS;
			ty = ((py & fmask) * stms_pkg::TILE_SIDE) >> stms_pkg::COORD_FRAC_BITS;
			// tile rows are stored bottom-up
			toffs = (stms_pkg::TILE_SIDE / 4) * (stms_pkg::TILE_SIDE - 1 - ty) + tx / 4;
			tshift = 2 * (tx % 4);
		endfunction

		// apply one accepted request; a sample leaves its colour in the queue
		function void note_request(stms_pkg::cmd_t op, logic [15:0] addr, logic [7:0] data,
				logic [7:0] col, logic [7:0] row, logic [7:0] tnum,
				logic [16:0] x, logic [16:0] y);
			sample_colour_t res;
			bit out;
			int unsigned caddr, cshift, cell_no, toffs, tshift;
			case (op)
				stms_pkg::CMD_COARSE: begin
					if (addr < stms_pkg::COARSE_BYTES) begin
						coarse_bytes[addr] = data;
						coarse_known[addr] = 1'b1;
					end
				end
				stms_pkg::CMD_TILE: begin
					if (addr < stms_pkg::TILE_STORE_BYTES) begin
						tile_bytes[addr] = data;
						tile_known[addr] = 1'b1;
					end
				end
				stms_pkg::CMD_BIND: begin
					cell_no = row * stms_pkg::MAP_SIDE_MAX + col;
					// a bound cell keeps its first tile
					if (col < stms_pkg::MAP_SIDE_MAX && row < stms_pkg::MAP_SIDE_MAX
							&& tnum < stms_pkg::MAX_TILES && !cell_bound[cell_no]) begin
						cell_bound[cell_no] = 1'b1;
						cell_tile[cell_no] = tnum;
					end
				end
				default: begin
					locate(x, y, out, caddr, cshift, cell_no, toffs, tshift);
					res.outside = out;
					res.pixel_class = 2'd0;
					res.source = stms_pkg::SRC_NONE;
					if (!out) begin
						res.pixel_class = 2'(coarse_bytes[caddr] >> cshift);
						if (res.pixel_class != 2'd0) begin
							res.source = stms_pkg::SRC_COARSE;
						end else if (cell_bound[cell_no]) begin
							res.pixel_class = 2'(tile_bytes[cell_tile[cell_no]
								* stms_pkg::TILE_BYTES + toffs] >> tshift);
							res.source = stms_pkg::SRC_TILE;
						end
					end
					// class zero, no tile and outside all come out white
					case (res.pixel_class)
						2'd1:    res.rgba = stms_pkg::COLOUR_ONE;
						2'd2:    res.rgba = stms_pkg::COLOUR_TWO;
						2'd3:    res.rgba = stms_pkg::COLOUR_THREE;
						default: res.rgba = stms_pkg::COLOUR_WHITE;
					endcase
					pending_samples.push_back(res);
				end
			endcase
		endfunction

		// compare one strobed colour with the oldest one awaited
		function void check_sample(logic [31:0] rgba_v, logic [1:0] cls_v, logic [1:0] src_v,
				logic out_v);
			sample_colour_t want;
			if (pending_samples.size() == 0) begin
				$display("%0t: colour with no sample pending, actual rgba %h", $time, rgba_v);
				errors++;
				return;
			end
			want = pending_samples.pop_front();
			if (rgba_v !== want.rgba) begin
				$display("%0t: rgba expected %h actual %h", $time, want.rgba, rgba_v);
				errors++;
			end
			if (cls_v !== want.pixel_class) begin
				$display("%0t: pixel_class expected %0d actual %0d", $time,
					want.pixel_class, cls_v);
				errors++;
			end
			if (src_v !== want.source) begin
				$display("%0t: colour_source expected %0d actual %0d", $time,
					want.source, src_v);
				errors++;
			end
			if (out_v !== want.outside) begin
				$display("%0t: outside_map expected %0d actual %0d", $time,
					want.outside, out_v);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [15:0] store_addr;
	logic [7:0]  store_byte;
	logic [7:0]  tile_col;
	logic [7:0]  tile_row;
	logic [7:0]  tile_number;
	logic [16:0] sample_x;
	logic [16:0] sample_y;
	logic        done;
	logic [31:0] rgba;
	logic [1:0]  pixel_class;
	logic [1:0]  colour_source;
	logic        outside_map;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	map_sample_scoreboard board = new();
	int unsigned idle_pct = 35;
	int unsigned quiet_cycles = 0;

	sparse_tile_map_sampler_core uut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .cmd(cmd), .store_addr(store_addr),
		.store_byte(store_byte), .tile_col(tile_col), .tile_row(tile_row),
		.tile_number(tile_number), .sample_x(sample_x), .sample_y(sample_y),
		.done(done), .rgba(rgba), .pixel_class(pixel_class),
		.colour_source(colour_source), .outside_map(outside_map),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result monitor: the strobe lasts one cycle and cannot be held off
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			board.check_sample(rgba, pixel_class, colour_source, outside_map);
	end

	// watchdog on cycles with neither a request nor a result taken
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// one request, with random idle cycles in front, held until taken
	task automatic send(stms_pkg::cmd_t op, logic [15:0] a, logic [7:0] d, logic [7:0] col,
			logic [7:0] row, logic [7:0] tnum, logic [16:0] x, logic [16:0] y);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		store_addr <= a;
		store_byte <= d;
		tile_col <= col;
		tile_row <= row;
		tile_number <= tnum;
		sample_x <= x;
		sample_y <= y;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_request(op, a, d, col, row, tnum, x, y);
	endtask

	// fields a command does not use carry noise
	task automatic put_coarse(int unsigned a, int unsigned d);
		send(stms_pkg::CMD_COARSE, 16'(a), 8'(d), 8'($urandom), 8'($urandom), 8'($urandom),
			17'($urandom), 17'($urandom));
	endtask

	task automatic put_tile(int unsigned a, int unsigned d);
		send(stms_pkg::CMD_TILE, 16'(a), 8'(d), 8'($urandom), 8'($urandom), 8'($urandom),
			17'($urandom), 17'($urandom));
	endtask

	task automatic put_bind(int unsigned col, int unsigned row, int unsigned tnum);
		send(stms_pkg::CMD_BIND, 16'($urandom), 8'($urandom), 8'(col), 8'(row), 8'(tnum),
			17'($urandom), 17'($urandom));
	endtask

	// sample a point, first filling any store byte it would read that was never written
	task automatic sample_point(logic [16:0] x, logic [16:0] y);
		bit out;
		int unsigned caddr, cshift, cell_no, toffs, tshift, taddr;
		board.locate(x, y, out, caddr, cshift, cell_no, toffs, tshift);
		if (!out) begin
			if (!board.coarse_known[caddr]) put_coarse(caddr, $urandom);
			taddr = board.cell_tile[cell_no] * stms_pkg::TILE_BYTES + toffs;
			if (2'(board.coarse_bytes[caddr] >> cshift) == 2'd0 && board.cell_bound[cell_no]
					&& !board.tile_known[taddr])
				put_tile(taddr, $urandom);
		end
		send(stms_pkg::CMD_SAMPLE, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), x, y);
	endtask

	// well-formed sequence around one in-map point: bind, coarse byte, tile byte, sample
	task automatic map_scene(logic [16:0] x, logic [16:0] y);
		bit out;
		int unsigned caddr, cshift, cell_no, toffs, tshift;
		int unsigned data;
		board.locate(x, y, out, caddr, cshift, cell_no, toffs, tshift);
		if (!out) begin
			if ($urandom_range(3) != 0)
				put_bind(cell_no % stms_pkg::MAP_SIDE_MAX, cell_no / stms_pkg::MAP_SIDE_MAX,
					$urandom);
			if (!board.coarse_known[caddr] || $urandom_range(1) == 1) begin
				data = $urandom;
				// mostly leave class zero here so the tile gets read
				if ($urandom_range(3) != 0) data = data & ~(32'd3 << cshift);
				put_coarse(caddr, data);
			end
			if (2'(board.coarse_bytes[caddr] >> cshift) == 2'd0 && board.cell_bound[cell_no]
					&& $urandom_range(1) == 1)
				put_tile(board.cell_tile[cell_no] * stms_pkg::TILE_BYTES + toffs, $urandom);
		end
		sample_point(x, y);
	endtask

	// one random step: mostly map scenes, the rest loose samples and noise writes
	task automatic random_request();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60) map_scene(17'($urandom_range(65535)), 17'($urandom_range(65535)));
		else if (pick < 70) sample_point(17'($urandom), 17'($urandom));
		else if (pick < 80) put_coarse($urandom_range(65535), $urandom);
		else if (pick < 90) put_tile($urandom_range(65535), $urandom);
		else put_bind($urandom, $urandom, $urandom);
	endtask

	// hold requests off until every colour is in and the pipeline has emptied
	task automatic settle();
		start <= 1'b0;
		while (board.pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write of the side register: setup cycle then access cycle
	task automatic write_quarter(logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= QW_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		board.set_quarter(value);
	endtask

	// stimulus
	initial begin
		int unsigned plan [9];
		int unsigned q;
		plan = '{1, 0, 127, 65, 64, 2, 0, 3, 33};
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= stms_pkg::CMD_COARSE;
		store_addr <= '0;
		store_byte <= '0;
		tile_col <= '0;
		tile_row <= '0;
		tile_number <= '0;
		sample_x <= '0;
		sample_y <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed, full-size map: coarse classes of cells 0..3 are 3, 2, 1, 0
		put_coarse(0, 8'h1B);
		sample_point(17'd0, 17'd0);
		sample_point(17'd256, 17'd0);
		sample_point(17'd512, 17'd0);
		// class zero with no tile bound
		sample_point(17'd768, 17'd0);
		// repeated bind keeps tile 255, not tile 7
		put_bind(3, 0, 255);
		put_bind(3, 0, 7);
		put_tile(255 * stms_pkg::TILE_BYTES + 248, 8'h02);
		put_tile(7 * stms_pkg::TILE_BYTES + 248, 8'h01);
		sample_point(17'd768, 17'd0);
		// far corner of the tile: last column of the top stored row
		put_tile(255 * stms_pkg::TILE_BYTES + 7, 8'hC0);
		sample_point(17'd1023, 17'd255);
		// last cell of the map, coarse first, then the tile behind it
		put_coarse(16383, 8'h40);
		put_bind(255, 255, 0);
		sample_point(17'h0FFFF, 17'h0FFFF);
		put_coarse(16383, 8'h00);
		put_tile(7, 8'h40);
		sample_point(17'h0FFFF, 17'h0FFFF);
		// points beyond the map
		sample_point(17'h10000, 17'd0);
		sample_point(17'd0, 17'h1FFFF);
		sample_point(17'h1FFFF, 17'h1FFFF);
		// writes past the coarse store are dropped; the tile write hits the last tile store byte
		put_coarse(16'h4000, 8'hAA);
		put_coarse(16'hFFFF, 8'hFF);
		put_tile(16'hFFFF, 8'hFF);
		sample_point(17'd0, 17'd0);
		repeat (30) random_request();

		// random phases, each after a write of the map size
		for (int p = 0; p < 9; p++) begin
			settle();
			q = (p == 6) ? $urandom_range(1, 127) : plan[p];
			write_quarter(($urandom & ~32'h7F) | q);
			idle_pct = (p == 4) ? 0 : 35;
			for (int i = 0; i < 24; i++) begin
				random_request();
				if ($urandom_range(49) == 0) settle();
			end
		end

		settle();
		if (board.errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/stms_pkg.sv
rtl/sparse_tile_map_sampler_core.sv
tb/sparse_tile_map_sampler_core_tb.sv
